// ===== rtl/dsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// dsfe_pkg
// Shared types, constants and the frame builder for the four-channel
// DShot frame encoder.
// ----------------------------------------------------------------------------
package dsfe_pkg;

	localparam int CHANNELS     = 4;
	localparam int FRAME_SLOTS  = 18;
	localparam int DATA_SLOTS   = 16;
	localparam int THR_W        = 11;
	localparam int PULSE_W      = 16;
	localparam int SLOT_W       = 5;
	localparam int FRAME_W      = 16;
	localparam int CSUM_W       = 4;

	localparam logic [SLOT_W-1:0]  LAST_SLOT     = SLOT_W'(FRAME_SLOTS - 1);
	localparam logic [SLOT_W-1:0]  DATA_SLOTS_SZ = SLOT_W'(DATA_SLOTS);
	localparam logic [PULSE_W-1:0] ONE_RESET     = PULSE_W'(420);
	localparam logic [PULSE_W-1:0] ZERO_RESET    = PULSE_W'(210);

	// configuration register indexes
	localparam logic REG_ONE_PULSE  = 1'b0;
	localparam logic REG_ZERO_PULSE = 1'b1;

	// one send request
	typedef struct packed {
		logic [THR_W-1:0] throttle_ch1;
		logic [THR_W-1:0] throttle_ch2;
		logic [THR_W-1:0] throttle_ch3;
		logic [THR_W-1:0] throttle_ch4;
	} req_t;

	// one slot result
	typedef struct packed {
		logic [SLOT_W-1:0]  slot_index;
		logic [PULSE_W-1:0] pulse_ch1;
		logic [PULSE_W-1:0] pulse_ch2;
		logic [PULSE_W-1:0] pulse_ch3;
		logic [PULSE_W-1:0] pulse_ch4;
		logic               last_slot;
	} slot_t;

	typedef logic [CHANNELS-1:0][FRAME_W-1:0] frame_set_t;

	// handoff between the frame stage and the slot sequencer
	typedef struct packed {
		logic       valid;
		frame_set_t frames;
	} frame_hand_t;

	// value = throttle << 1 (telemetry bit zero), checksum over three nibbles
	function automatic logic [FRAME_W-1:0] make_frame(input logic [THR_W-1:0] thr);
		logic [FRAME_W-CSUM_W-1:0] value;
		logic [CSUM_W-1:0]         csum;
		value = {thr, 1'b0};
		csum  = value[3:0] ^ value[7:4] ^ value[11:8];
		return {value, csum};
	endfunction

endpackage

// ===== rtl/dsfe_frame_stage.sv =====
// ----------------------------------------------------------------------------
// dsfe_frame_stage
// Input register: builds the four 16-bit frames of a request as it is
// accepted and holds them until the slot sequencer takes them.
// ----------------------------------------------------------------------------
module dsfe_frame_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  dsfe_pkg::req_t        req,
	input  logic                  take,
	output dsfe_pkg::frame_hand_t hand
);

	logic                 valid_s1;
	dsfe_pkg::frame_set_t frames_s1;

	// free when empty or when the held item leaves this cycle
	assign req_ready = !valid_s1 || take;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// frame payload
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			frames_s1[0] <= dsfe_pkg::make_frame(req.throttle_ch1);
			frames_s1[1] <= dsfe_pkg::make_frame(req.throttle_ch2);
			frames_s1[2] <= dsfe_pkg::make_frame(req.throttle_ch3);
			frames_s1[3] <= dsfe_pkg::make_frame(req.throttle_ch4);
		end
	end

	assign hand.valid  = valid_s1;
	assign hand.frames = frames_s1;

endmodule

// ===== rtl/dsfe_slot_seq.sv =====
// ----------------------------------------------------------------------------
// dsfe_slot_seq
// Slot sequencer: walks the held frames MSB first into an output register,
// one slot per cycle when not stalled; trailing slots carry zero pulses.
// ----------------------------------------------------------------------------
module dsfe_slot_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dsfe_pkg::frame_hand_t          hand,
	output logic                           take,
	input  logic [dsfe_pkg::PULSE_W-1:0]   one_width,
	input  logic [dsfe_pkg::PULSE_W-1:0]   zero_width,
	output logic                           slot_valid,
	input  logic                           slot_ready,
	output dsfe_pkg::slot_t                slot
);

	logic                             active_q;
	logic [dsfe_pkg::SLOT_W-1:0]      slot_q;
	dsfe_pkg::frame_set_t             frames_q;
	logic                             out_valid_q;
	dsfe_pkg::slot_t                  out_q;

	logic                             adv;
	logic                             emit;
	logic                             fin;
	logic                             data_slot;
	logic [3:0]                       bit_idx;
	logic [dsfe_pkg::CHANNELS-1:0][dsfe_pkg::PULSE_W-1:0] pulse;
	dsfe_pkg::slot_t                  nxt;

	// handshake control
	assign adv  = !out_valid_q || slot_ready;
	assign emit = active_q && adv;
	assign fin  = emit && (slot_q == dsfe_pkg::LAST_SLOT);
	assign take = hand.valid && (!active_q || fin);

	// pulse selection for the current slot
	assign data_slot = slot_q < dsfe_pkg::DATA_SLOTS_SZ;
	assign bit_idx   = 4'(dsfe_pkg::DATA_SLOTS - 1) - slot_q[3:0];

	always_comb begin
		for (int c = 0; c < dsfe_pkg::CHANNELS; c++) begin
			if (!data_slot) begin
				pulse[c] = '0;
			end else if (frames_q[c][bit_idx]) begin
				pulse[c] = one_width;
			end else begin
				pulse[c] = zero_width;
			end
		end
		nxt.slot_index = slot_q;
		nxt.pulse_ch1  = pulse[0];
		nxt.pulse_ch2  = pulse[1];
		nxt.pulse_ch3  = pulse[2];
		nxt.pulse_ch4  = pulse[3];
		nxt.last_slot  = (slot_q == dsfe_pkg::LAST_SLOT);
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				active_q <= 1'b1;
				slot_q   <= '0;
			end else if (fin) begin
				active_q <= 1'b0;
			end else if (emit) begin
				slot_q <= slot_q + 1'b1;
			end
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			frames_q <= hand.frames;
		end
		if (emit) begin
			out_q <= nxt;
		end
	end

	assign slot_valid = out_valid_q;
	assign slot       = out_q;

	// checks
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> slot_q <= dsfe_pkg::LAST_SLOT)
		else $error("slot counter out of range");

	a_slot_step: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !fin) |=> (active_q && slot_q == $past(slot_q) + 1'b1))
		else $error("slot counter did not advance");

	a_take_start: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (active_q && slot_q == '0))
		else $error("new frame did not start at slot zero");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.last_slot == (out_q.slot_index == dsfe_pkg::LAST_SLOT)))
		else $error("last slot flag mismatch");

endmodule

// ===== rtl/dshot_four_channel_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// dshot_four_channel_frame_encoder
// Four-channel DShot frame encoder: one request in, eighteen slot items out.
// ----------------------------------------------------------------------------
// Each accepted request carries four 11-bit throttle values; every channel is
// turned into a 16-bit DShot frame (throttle << 1, telemetry bit zero, 4-bit
// XOR checksum) and then sent as 18 slot items, frame MSB first: slots 0-15
// carry one_pulse_width or zero_pulse_width per frame bit, slots 16-17 carry
// zero, and last_slot marks slot 17. The slot sequencer emits one slot per
// cycle unless slot_ready stalls it; each request passes through the input
// register, sequencer state and output register. A second request is held
// in the input register and starts right after the last slot of the one
// before, so back-to-back requests stream with no idle slot between them.
// Configuration registers: index 0 one_pulse_width (reset 420), index 1
// zero_pulse_width (reset 210); write them only while the block is idle.
module dshot_four_channel_frame_encoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  dsfe_pkg::req_t               req,
	output logic                         slot_valid,
	input  logic                         slot_ready,
	output dsfe_pkg::slot_t              slot,
	input  logic                         cfg_write,
	input  logic                         cfg_index,
	input  logic [dsfe_pkg::PULSE_W-1:0] cfg_data
);

	logic [dsfe_pkg::PULSE_W-1:0] one_width_q;
	logic [dsfe_pkg::PULSE_W-1:0] zero_width_q;
	dsfe_pkg::frame_hand_t        hand;
	logic                         take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_width_q  <= dsfe_pkg::ONE_RESET;
			zero_width_q <= dsfe_pkg::ZERO_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				dsfe_pkg::REG_ONE_PULSE:  one_width_q  <= cfg_data;
				dsfe_pkg::REG_ZERO_PULSE: zero_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dsfe_frame_stage u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.take      (take),
		.hand      (hand)
	);

	dsfe_slot_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.hand       (hand),
		.take       (take),
		.one_width  (one_width_q),
		.zero_width (zero_width_q),
		.slot_valid (slot_valid),
		.slot_ready (slot_ready),
		.slot       (slot)
	);

endmodule
